// ===== rtl/core/bdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcd_pkg
// Shared types and constants for the button debounce / click detector.
// ----------------------------------------------------------------------------
package bdcd_pkg;

    localparam int LANES        = 4;
    localparam int BUTTON_COUNT = 4;

    localparam int DEB_W  = 8;
    localparam int HOLD_W = 16;
    localparam int EV_W   = 3;

    localparam logic [DEB_W-1:0]  DEB_MAX  = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd3;
    localparam logic [HOLD_W-1:0] LONG_RST     = 16'd100;
    localparam logic [HOLD_W-1:0] RELEASE_RST  = 16'd30;
    localparam logic [LANES-1:0]  PRESS_RST    = 4'd0;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_RELEASE  = 2'd2,
        REG_PRESS    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2,
        PH_LONG     = 2'd3
    } t_phase;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_CLICK1  = 3'd4,
        EV_CLICK2  = 3'd5
    } t_event;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_limit;
        logic [HOLD_W-1:0] long_limit;
        logic [HOLD_W-1:0] release_limit;
    } t_lane_cfg;

    typedef struct packed {
        logic [LANES-1:0][EV_W-1:0] events;
        logic [LANES-1:0]           mask;
    } t_result;

endpackage

// ===== rtl/core/bdcd_lane.sv =====
// ----------------------------------------------------------------------------
// bdcd_lane
// One button: debouncer followed by the press / click / long-press machine.
// ----------------------------------------------------------------------------
module bdcd_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_raw,
    input  logic                         i_press_level,
    input  logic                         i_reload,
    input  logic                         i_reload_level,
    input  bdcd_pkg::t_lane_cfg          i_cfg,
    output logic [bdcd_pkg::EV_W-1:0]    o_event,
    output logic                         o_down
);
    import bdcd_pkg::*;

    logic              r_stable, n_stable;
    logic [DEB_W-1:0]  r_glitch, n_glitch;
    logic [HOLD_W-1:0] r_hold, n_hold;
    t_phase            r_phase, n_phase;
    logic              r_second, n_second;

    logic [DEB_W-1:0]  glitch_inc;
    logic [HOLD_W-1:0] hold_inc;
    logic              down;
    t_event            ev;

    // debounce
    always_comb begin
        hold_inc   = (r_phase != PH_IDLE && r_hold != HOLD_MAX) ? r_hold + 1'b1 : r_hold;
        glitch_inc = (r_glitch != DEB_MAX) ? r_glitch + 1'b1 : r_glitch;
        n_stable   = r_stable;
        n_glitch   = '0;
        if (r_stable != i_raw) begin
            if (glitch_inc > i_cfg.debounce_limit) begin
                n_stable = i_raw;
            end else begin
                n_glitch = glitch_inc;
            end
        end
        down = (n_stable == i_press_level);
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (down) n_phase = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (!down) n_phase = PH_RELEASED;
                else if (hold_inc > i_cfg.long_limit) n_phase = PH_LONG;
            end
            PH_RELEASED: begin
                if (down) n_phase = PH_PRESSED;
                else if (hold_inc > i_cfg.release_limit) n_phase = PH_IDLE;
            end
            PH_LONG: begin
                if (!down) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // events and counters
    always_comb begin
        ev       = EV_NONE;
        n_hold   = hold_inc;
        n_second = r_second;
        unique case (r_phase)
            PH_IDLE: begin
                if (down) begin
                    ev     = EV_PRESS;
                    n_hold = '0;
                end
            end
            PH_PRESSED: begin
                if (!down) begin
                    ev     = EV_RELEASE;
                    n_hold = '0;
                end else if (hold_inc > i_cfg.long_limit) begin
                    ev     = EV_LONG;
                    n_hold = '0;
                end
            end
            PH_RELEASED: begin
                if (down) begin
                    ev       = EV_PRESS;
                    n_second = 1'b1;
                    n_hold   = '0;
                end else if (hold_inc > i_cfg.release_limit) begin
                    ev       = r_second ? EV_CLICK2 : EV_CLICK1;
                    n_second = 1'b0;
                end
            end
            PH_LONG: begin
                if (!down) begin
                    ev     = EV_RELEASE;
                    n_hold = '0;
                end
            end
            default: ev = EV_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= ~PRESS_RST[0];
            r_glitch <= '0;
            r_hold   <= '0;
            r_phase  <= PH_IDLE;
            r_second <= 1'b0;
        end else if (i_reload) begin
            r_stable <= ~i_reload_level;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_glitch <= n_glitch;
            r_hold   <= n_hold;
            r_phase  <= n_phase;
            r_second <= n_second;
        end
    end

    assign o_event = ev;
    assign o_down  = down;

endmodule

// ===== rtl/core/bdcd_merge.sv =====
// ----------------------------------------------------------------------------
// bdcd_merge
// Collects the lane events and pressed bits into one result beat and holds
// it in a two-entry output buffer.
// ----------------------------------------------------------------------------
module bdcd_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_fire,
    input  logic [bdcd_pkg::LANES-1:0][bdcd_pkg::EV_W-1:0] i_events,
    input  logic [bdcd_pkg::LANES-1:0]                  i_down,
    output logic                                        o_in_ready,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output bdcd_pkg::t_result                           o_result
);
    import bdcd_pkg::*;

    t_result r_main, r_skid, beat;
    logic    r_main_valid, r_skid_valid;
    logic    out_fire;

    always_comb begin
        beat.events = i_events;
        beat.mask   = i_down;
    end

    assign out_fire = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_main_valid) begin
            r_main_valid <= r_skid_valid || i_in_fire;
            r_skid_valid <= 1'b0;
        end else if (i_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : beat;
        end else if (i_in_fire) begin
            r_skid <= beat;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_result   = r_main;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without main entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_fire && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("beat lost while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready) |=> (r_main_valid && $stable(r_main)))
        else $error("output beat changed while stalled");

endmodule

// ===== rtl/core/button_debounce_click_detector.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Four-lane debouncer with press, release, long press and click events.
// Result beats are registered in the output buffer's main entry (skid on stall).
// Throughput: one tick per cycle while the skid entry is free; lanes update
// in the accept cycle and the two-entry output buffer absorbs output stalls.
// Reset (synchronous): limits 3/100/30, press levels 0, lanes idle,
// debounced levels released, output buffer empty.
// ----------------------------------------------------------------------------
module button_debounce_click_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_raw_valid,
    output logic                          o_raw_ready,
    input  logic [bdcd_pkg::LANES-1:0]    i_raw_levels,
    output logic                          o_evt_valid,
    input  logic                          i_evt_ready,
    output logic [bdcd_pkg::EV_W-1:0]     o_event_button0,
    output logic [bdcd_pkg::EV_W-1:0]     o_event_button1,
    output logic [bdcd_pkg::EV_W-1:0]     o_event_button2,
    output logic [bdcd_pkg::EV_W-1:0]     o_event_button3,
    output logic [bdcd_pkg::LANES-1:0]    o_pressed_mask
);
    import bdcd_pkg::*;

    logic [DEB_W-1:0]  r_debounce_limit;
    logic [HOLD_W-1:0] r_long_limit;
    logic [HOLD_W-1:0] r_release_limit;
    logic [LANES-1:0]  r_press_levels;

    t_reg_idx  reg_idx;
    logic      wr_en;
    logic      press_wr;
    logic      in_fire;
    t_lane_cfg lane_cfg;
    t_result   result;

    logic [LANES-1:0][EV_W-1:0] lane_events;
    logic [LANES-1:0]           lane_down;

    assign reg_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en    = psel && penable && pwrite && pready;
    assign press_wr = wr_en && (reg_idx == REG_PRESS);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= DEBOUNCE_RST;
            r_long_limit     <= LONG_RST;
            r_release_limit  <= RELEASE_RST;
            r_press_levels   <= PRESS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE: r_debounce_limit <= pwdata[DEB_W-1:0];
                REG_LONG:     r_long_limit     <= pwdata[HOLD_W-1:0];
                REG_RELEASE:  r_release_limit  <= pwdata[HOLD_W-1:0];
                REG_PRESS:    r_press_levels   <= pwdata[LANES-1:0];
                default:      r_press_levels   <= r_press_levels;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DEBOUNCE: prdata[DEB_W-1:0]  = r_debounce_limit;
            REG_LONG:     prdata[HOLD_W-1:0] = r_long_limit;
            REG_RELEASE:  prdata[HOLD_W-1:0] = r_release_limit;
            REG_PRESS:    prdata[LANES-1:0]  = r_press_levels;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        lane_cfg.debounce_limit = r_debounce_limit;
        lane_cfg.long_limit     = r_long_limit;
        lane_cfg.release_limit  = r_release_limit;
    end

    assign in_fire = i_raw_valid && o_raw_ready;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k < BUTTON_COUNT) begin : g_used
            bdcd_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_step         (in_fire),
                .i_raw          (i_raw_levels[k]),
                .i_press_level  (r_press_levels[k]),
                .i_reload       (press_wr),
                .i_reload_level (pwdata[k]),
                .i_cfg          (lane_cfg),
                .o_event        (lane_events[k]),
                .o_down         (lane_down[k])
            );
        end else begin : g_unused
            assign lane_events[k] = EV_NONE;
            assign lane_down[k]   = 1'b0;
        end
    end

    bdcd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_events   (lane_events),
        .i_down     (lane_down),
        .o_in_ready (o_raw_ready),
        .o_valid    (o_evt_valid),
        .i_ready    (i_evt_ready),
        .o_result   (result)
    );

    assign o_event_button0 = result.events[0];
    assign o_event_button1 = result.events[1];
    assign o_event_button2 = result.events[2];
    assign o_event_button3 = result.events[3];
    assign o_pressed_mask  = result.mask;

endmodule
